### hw/rtl/had_pkg.sv
package had_pkg;

   // Input transaction: start and end points of the vector.
   typedef struct packed {
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
   } req_type;

   // Result transaction: heading in 1/128 degree and the zero-length flag.
   typedef struct packed {
      logic [15:0] heading;
      logic        zero_vector;
   } rsp_type;

   // Coordinate difference width and the left shift applied before the iterations.
   localparam int DIFF_W      = 17;
   localparam int COORD_SHIFT = 20;
   // Working width of x and y; covers the CORDIC gain with margin.
   localparam int XY_W        = 41;
   // Angle accumulator width, in 1/65536 degree.
   localparam int Z_W         = 26;
   // Width of the clamped and reflected angle, 0 to 360 degrees.
   localparam int ZR_W        = 25;

   localparam logic signed [Z_W-1:0] ANG_90  = 26'sd5898240;
   localparam logic signed [Z_W-1:0] ANG_180 = 26'sd11796480;
   localparam logic [ZR_W-1:0]       ANG_360 = 25'd23592960;
   localparam logic [ZR_W-1:0]       ROUND_HALF = 25'd256;
   localparam int                    OUT_SHIFT  = 9;
   localparam logic [15:0]           FULL_TURN_OUT = 16'd46080;

   // Arctangent of 2^-i in 1/65536 degree; steps beyond the table add nothing.
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 26'sd2949120;
         5'd1:    val = 26'sd1740967;
         5'd2:    val = 26'sd919879;
         5'd3:    val = 26'sd466945;
         5'd4:    val = 26'sd234379;
         5'd5:    val = 26'sd117304;
         5'd6:    val = 26'sd58666;
         5'd7:    val = 26'sd29335;
         5'd8:    val = 26'sd14668;
         5'd9:    val = 26'sd7334;
         5'd10:   val = 26'sd3667;
         5'd11:   val = 26'sd1833;
         5'd12:   val = 26'sd917;
         5'd13:   val = 26'sd458;
         5'd14:   val = 26'sd229;
         5'd15:   val = 26'sd115;
         5'd16:   val = 26'sd57;
         5'd17:   val = 26'sd29;
         5'd18:   val = 26'sd14;
         5'd19:   val = 26'sd7;
         5'd20:   val = 26'sd4;
         5'd21:   val = 26'sd2;
         5'd22:   val = 26'sd1;
         default: val = 26'sd0;
      endcase
      return val;
   endfunction

endpackage

### hw/rtl/heading_angle_degrees_unit.sv
// Heading angle unit: returns the direction of the vector from a start point
// to an end point, in 1/128 degree, from 0 up to but not including 360 degrees.
//
// Input channel req_*: one transaction carries both points as a req_type.
// Result channel rsp_*: one transaction per input, in order, as a rsp_type.
// A zero-length vector gives heading 0 with zero_vector set.
//
// The datapath is a pipeline of CORDIC_STEPS + 3 register stages: one stage
// forms the difference vector, one stage per CORDIC iteration, one stage
// clamps and reflects the angle, and one output register rounds it.
// A new transaction is taken every cycle unless a receiver stall has filled
// the pipeline back to the input.
//
// When the receiver stalls, stages hold their contents; empty stages still
// fill, so the input keeps accepting until every stage holds a transaction.
// Synchronous reset empties the pipeline; nothing is presented on rsp_valid
// until new transactions arrive.
module heading_angle_degrees_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  had_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output had_pkg::rsp_type   rsp_data
);

   localparam int STAGES = CORDIC_STEPS + 3;
   localparam int LAST   = STAGES - 1;
   localparam int CLAMP  = CORDIC_STEPS + 1;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   stage_ready;

   logic signed [had_pkg::XY_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [had_pkg::XY_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [had_pkg::Z_W-1:0]  z_ff [0:CORDIC_STEPS];
   logic [CORDIC_STEPS+1:0]         neg_ff;
   logic [CORDIC_STEPS+1:0]         neg_in;
   logic [CORDIC_STEPS+1:0]         zero_ff;
   logic [CORDIC_STEPS+1:0]         zero_in;
   logic [had_pkg::ZR_W-1:0]        zr_ff;
   logic [had_pkg::ZR_W-1:0]        zr_in;
   had_pkg::rsp_type                rsp_ff;
   had_pkg::rsp_type                rsp_in;

   // A stage may load when it is empty or its content moves on.
   assign stage_ready[STAGES] = rsp_ready;
   for (genvar s = 0; s < STAGES; s++) begin : g_ready
      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
   end

   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};
   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[LAST];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Difference vector, fold into the right half-plane and seed the iterations.
   logic signed [had_pkg::DIFF_W-1:0] dx;
   logic signed [had_pkg::DIFF_W-1:0] dy;
   logic signed [had_pkg::DIFF_W-1:0] ady;
   logic signed [had_pkg::DIFF_W-1:0] ndx;
   logic signed [had_pkg::XY_W-1:0]   x0_in;
   logic signed [had_pkg::XY_W-1:0]   y0_in;
   logic signed [had_pkg::Z_W-1:0]    z0_in;

   always_comb begin
      dx  = {req_data.end_x[15], req_data.end_x} - {req_data.start_x[15], req_data.start_x};
      dy  = {req_data.end_y[15], req_data.end_y} - {req_data.start_y[15], req_data.start_y};
      ady = dy[had_pkg::DIFF_W-1] ? -dy : dy;
      ndx = -dx;
      if (dx[had_pkg::DIFF_W-1]) begin
         x0_in = had_pkg::XY_W'(ady) <<< had_pkg::COORD_SHIFT;
         y0_in = had_pkg::XY_W'(ndx) <<< had_pkg::COORD_SHIFT;
         z0_in = had_pkg::ANG_90;
      end else begin
         x0_in = had_pkg::XY_W'(dx) <<< had_pkg::COORD_SHIFT;
         y0_in = had_pkg::XY_W'(ady) <<< had_pkg::COORD_SHIFT;
         z0_in = '0;
      end
   end

   // Sign and zero-length flags ride along with each transaction.
   assign neg_in  = {neg_ff[CORDIC_STEPS:0], dy[had_pkg::DIFF_W-1]};
   assign zero_in = {zero_ff[CORDIC_STEPS:0], (dx == '0) && (dy == '0)};

   always_ff @(posedge clock) begin
      for (int s = 0; s <= CORDIC_STEPS + 1; s++) begin
         if (stage_ready[s]) begin
            neg_ff[s]  <= neg_in[s];
            zero_ff[s] <= zero_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
      end
   end

   // One vectoring CORDIC iteration per stage; the shift is fixed per stage.
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      logic signed [had_pkg::XY_W-1:0] xs;
      logic signed [had_pkg::XY_W-1:0] ys;
      logic signed [had_pkg::XY_W-1:0] x_in;
      logic signed [had_pkg::XY_W-1:0] y_in;
      logic signed [had_pkg::Z_W-1:0]  z_in;

      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;

      always_comb begin
         if (!y_ff[k][had_pkg::XY_W-1]) begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + had_pkg::atan_q16(5'(k));
         end else begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - had_pkg::atan_q16(5'(k));
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[k+1]) begin
            x_ff[k+1] <= x_in;
            y_ff[k+1] <= y_in;
            z_ff[k+1] <= z_in;
         end
      end
   end

   // Clamp to 0..180 degrees, then reflect for a negative y difference.
   logic signed [had_pkg::Z_W-1:0] z_clamped;

   always_comb begin
      if (z_ff[CORDIC_STEPS][had_pkg::Z_W-1]) begin
         z_clamped = '0;
      end else if (z_ff[CORDIC_STEPS] > had_pkg::ANG_180) begin
         z_clamped = had_pkg::ANG_180;
      end else begin
         z_clamped = z_ff[CORDIC_STEPS];
      end
      if (neg_ff[CORDIC_STEPS]) begin
         zr_in = had_pkg::ANG_360 - had_pkg::ZR_W'(z_clamped);
      end else begin
         zr_in = had_pkg::ZR_W'(z_clamped);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[CLAMP]) begin
         zr_ff <= zr_in;
      end
   end

   // Round half up to 1/128 degree, wrap a full turn to zero and zero a zero-length vector.
   logic [had_pkg::ZR_W-1:0] zr_round;
   logic [15:0]              heading_raw;

   always_comb begin
      zr_round    = zr_ff + had_pkg::ROUND_HALF;
      heading_raw = 16'(zr_round >> had_pkg::OUT_SHIFT);
      rsp_in.zero_vector = zero_ff[CLAMP];
      if (zero_ff[CLAMP] || (heading_raw >= had_pkg::FULL_TURN_OUT)) begin
         rsp_in.heading = '0;
      end else begin
         rsp_in.heading = heading_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   // A reset leaves no transaction in flight.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A zero-length vector always reports heading zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |-> rsp_data.heading == '0)
      else $error("zero vector with nonzero heading");

   // The heading never reaches a full turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading < had_pkg::FULL_TURN_OUT)
      else $error("heading out of range");

   // A negative y difference lands in the lower half-turn after reflection.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[CLAMP] && neg_ff[CLAMP] |->
         zr_ff >= had_pkg::ZR_W'(had_pkg::ANG_180) && zr_ff <= had_pkg::ANG_360)
      else $error("reflected angle out of range");

endmodule
